FILE: src/assert_macros.svh
// Assertion helpers shared by the histogram modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define LNH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define LNH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lnh_pkg.sv
package lnh_pkg;

    localparam int MAX_GRAM_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int ALPHABET        = 26;

    localparam int LETTER_W   = 5;
    localparam int OP_W       = 1;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 19;
    localparam int OUT_W      = 32;
    localparam int CFG_LEN_W  = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_FEED = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_GRAM_LEN = 1'b0;
    localparam logic [CFG_LEN_W-1:0] GRAM_LEN_RST = 3'd4;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;

    // Command flags passed from the front end to the table pipeline
    typedef struct packed {
        logic is_read;
        logic do_count;
        logic in_table;
    } t_ctl;

    function automatic int pow26(input int e);
        int r;
        r = 1;
        for (int k = 0; k < e; k++) begin
            r = r * ALPHABET;
        end
        return r;
    endfunction

endpackage

FILE: src/lnh_front.sv
`include "assert_macros.svh"

module lnh_front #(
    parameter int MAX_GRAM = lnh_pkg::MAX_GRAM_DEF,
    parameter int AW       = $clog2(lnh_pkg::pow26(lnh_pkg::MAX_GRAM_DEF))
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [lnh_pkg::OP_W-1:0]        i_op,
    input  logic [lnh_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic [lnh_pkg::INDEX_W-1:0]     i_entry_index,
    input  logic [lnh_pkg::CFG_LEN_W-1:0]   i_gram_length,
    output lnh_pkg::t_ctl                   o_ctl,
    output logic [AW-1:0]                   o_addr
);
    import lnh_pkg::*;

    localparam int TABLE_SIZE = pow26(MAX_GRAM);
    localparam int WIN        = (MAX_GRAM > 1) ? MAX_GRAM - 1 : 1;
    localparam int FILL_MAX   = MAX_GRAM - 1;
    localparam int FW         = (MAX_GRAM > 2) ? $clog2(MAX_GRAM) : 1;
    localparam int LW         = $clog2(MAX_GRAM + 1);

    logic [LETTER_W-1:0] r_win [WIN];
    logic [FW-1:0]       r_fill;

    logic                is_upper;
    logic                is_lower;
    logic                letter;
    logic                take_letter;
    logic [LETTER_W-1:0] code;
    logic [LW-1:0]       eff;
    logic                count_ok;
    logic [AW-1:0]       gram_idx;
    logic                idx_ok;

    assign is_upper = (i_text_byte >= CH_UPPER_A) && (i_text_byte <= CH_UPPER_Z);
    assign is_lower = (i_text_byte >= CH_LOWER_A) && (i_text_byte <= CH_LOWER_Z);
    assign letter   = is_upper || is_lower;
    assign take_letter = i_accept && (i_op == OP_FEED) && letter;

    always_comb begin
        if (is_upper) begin
            code = LETTER_W'(i_text_byte - CH_UPPER_A);
        end else begin
            code = LETTER_W'(i_text_byte - CH_LOWER_A);
        end
    end

    // Clamp the programmed length into 1..MAX_GRAM
    always_comb begin
        if (i_gram_length == '0) begin
            eff = LW'(1);
        end else if (int'(i_gram_length) > MAX_GRAM) begin
            eff = LW'(MAX_GRAM);
        end else begin
            eff = LW'(i_gram_length);
        end
    end

    assign count_ok = (r_fill >= FW'(eff - LW'(1)));

    // Base-26 index, oldest letter most significant
    always_comb begin
        gram_idx = AW'(code);
        for (int i = 0; i < WIN; i++) begin
            if (LW'(i + 1) < eff) begin
                gram_idx = gram_idx + AW'(r_win[i]) * AW'(pow26(i + 1));
            end
        end
    end

    assign idx_ok = (int'(i_entry_index) < TABLE_SIZE);

    always_comb begin
        o_ctl.is_read  = (i_op == OP_READ);
        o_ctl.do_count = (i_op == OP_FEED) && letter && count_ok;
        o_ctl.in_table = (i_op == OP_READ) ? idx_ok : 1'b1;
        o_addr         = (i_op == OP_READ) ? AW'(i_entry_index) : gram_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= '0;
            end
        end else if (take_letter) begin
            r_win[0] <= code;
            for (int i = 1; i < WIN; i++) begin
                r_win[i] <= r_win[i-1];
            end
            if (r_fill < FW'(FILL_MAX)) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    `LNH_ASSERT_NEXT(a_fill_on_letter_only, i_clk, i_rst_n, !take_letter, $stable(r_fill), "window fill moved without a letter")

endmodule

FILE: src/lnh_queue.sv
module lnh_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid,
    output logic              o_full
);
    import lnh_pkg::*;

    logic [DATA_W-1:0]  r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_data  = r_slot[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/lnh_back.sv
`include "assert_macros.svh"

module lnh_back #(
    parameter int MAX_GRAM    = lnh_pkg::MAX_GRAM_DEF,
    parameter int COUNT_WIDTH = lnh_pkg::COUNT_WIDTH_DEF,
    parameter int AW          = $clog2(lnh_pkg::pow26(lnh_pkg::MAX_GRAM_DEF))
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  lnh_pkg::t_ctl               i_q_ctl,
    input  logic [AW-1:0]               i_q_addr,
    output logic                        o_pop,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [lnh_pkg::OUT_W-1:0]   o_entry_count,
    output logic [lnh_pkg::OUT_W-1:0]   o_total_count,
    output logic                        o_clr_busy
);
    import lnh_pkg::*;

    localparam int TABLE_SIZE = pow26(MAX_GRAM);
    localparam int CW         = COUNT_WIDTH;

    logic [CW-1:0] r_mem [TABLE_SIZE];

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_b_valid;
    t_ctl          r_b_ctl;
    logic [AW-1:0] r_b_addr;
    logic [CW-1:0] r_rd_data;

    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [CW-1:0] r_fwd_data;

    logic [CW-1:0] r_total;
    logic          r_out_valid;
    logic [OUT_W-1:0] r_out_entry;
    logic [OUT_W-1:0] r_out_total;

    logic          b_go;
    logic          b_take;
    logic [CW-1:0] cur;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] n_total;
    logic          upd_wr;
    logic          w_en;
    logic [AW-1:0] w_addr;
    logic [CW-1:0] w_data;

    assign b_go   = r_b_valid && (!r_out_valid || i_out_ready);
    assign b_take = !r_b_valid || b_go;
    assign o_pop  = i_q_valid && b_take;

    // Take the last write when it hit the same entry after this read was issued
    assign cur     = (r_fwd_valid && (r_fwd_addr == r_b_addr)) ? r_fwd_data : r_rd_data;
    assign n_cnt   = (cur == '1) ? cur : cur + CW'(1);
    assign n_total = (r_b_ctl.do_count && (r_total != '1)) ? r_total + CW'(1) : r_total;
    assign upd_wr  = b_go && r_b_ctl.do_count;

    always_comb begin
        if (r_clr_busy) begin
            w_en   = 1'b1;
            w_addr = r_clr_addr;
            w_data = '0;
        end else begin
            w_en   = upd_wr;
            w_addr = r_b_addr;
            w_data = n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[i_q_addr];
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_ctl  <= i_q_ctl;
            r_b_addr <= i_q_addr;
        end
        if (upd_wr) begin
            r_fwd_addr <= r_b_addr;
            r_fwd_data <= n_cnt;
        end
        if (b_go) begin
            r_out_entry <= (r_b_ctl.is_read && r_b_ctl.in_table) ? OUT_W'(cur) : '0;
            r_out_total <= OUT_W'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(TABLE_SIZE - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (upd_wr) begin
                r_fwd_valid <= 1'b1;
            end
            if (b_go) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_count = r_out_entry;
    assign o_total_count = r_out_total;
    assign o_clr_busy    = r_clr_busy;

    `LNH_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_clr_busy, !r_b_valid && !r_out_valid && !i_q_valid, "request in flight during table clear")
    `LNH_ASSERT_IMP(a_total_rises, i_clk, i_rst_n, $past(i_rst_n), r_total >= $past(r_total), "total count fell")

endmodule

FILE: src/letter_ngram_histogram_core.sv
// Channel  | Direction | Handshake                 | Payload
// in       | to core   | i_in_valid / o_in_ready   | i_op, i_text_byte, i_entry_index
// out      | from core | o_out_valid / i_out_ready | o_entry_count, o_total_count
// config   | to core   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One request per cycle sustained while the output is taken; a result passes the queue
// write at acceptance, the table read and the output register before it is valid.
// After reset the count table is cleared one entry a cycle, all 26^MAX_GRAM entries
// (456976 at MAX_GRAM = 4); o_in_ready stays low until the clear ends.
// A stalled output first fills the output register, then the table pipeline, then the
// four-entry request queue, and only then drops o_in_ready.
// Table counts are read-modify-written in two stages with the last write forwarded.
module letter_ngram_histogram_core #(
    parameter int MAX_GRAM    = lnh_pkg::MAX_GRAM_DEF,
    parameter int COUNT_WIDTH = lnh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lnh_pkg::OP_W-1:0]        i_op,
    input  logic [lnh_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic [lnh_pkg::INDEX_W-1:0]     i_entry_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lnh_pkg::OUT_W-1:0]       o_entry_count,
    output logic [lnh_pkg::OUT_W-1:0]       o_total_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lnh_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lnh_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lnh_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import lnh_pkg::*;

    localparam int TABLE_SIZE = pow26(MAX_GRAM);
    localparam int AW         = $clog2(TABLE_SIZE);
    localparam int QW         = $bits(t_ctl) + AW;

    logic [CFG_LEN_W-1:0] r_gram_length;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    logic          accept;
    t_ctl          f_ctl;
    logic [AW-1:0] f_addr;
    logic [QW-1:0] q_data;
    logic          q_valid;
    logic          q_full;
    logic          q_pop;
    t_ctl          q_ctl;
    logic [AW-1:0] q_addr;
    logic          clr_busy;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_GRAM_LEN);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_GRAM_LEN) ? APB_DATA_W'(r_gram_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gram_length <= GRAM_LEN_RST;
        end else if (cfg_wr) begin
            r_gram_length <= pwdata[CFG_LEN_W-1:0];
        end
    end

    assign o_in_ready = !q_full && !clr_busy;
    assign accept     = i_in_valid && o_in_ready;

    lnh_front #(
        .MAX_GRAM (MAX_GRAM),
        .AW       (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_text_byte   (i_text_byte),
        .i_entry_index (i_entry_index),
        .i_gram_length (r_gram_length),
        .o_ctl         (f_ctl),
        .o_addr        (f_addr)
    );

    lnh_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_ctl, f_addr}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    assign q_ctl  = t_ctl'(q_data[QW-1:AW]);
    assign q_addr = q_data[AW-1:0];

    lnh_back #(
        .MAX_GRAM    (MAX_GRAM),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_ctl       (q_ctl),
        .i_q_addr      (q_addr),
        .o_pop         (q_pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_entry_count (o_entry_count),
        .o_total_count (o_total_count),
        .o_clr_busy    (clr_busy)
    );

endmodule
